>>> sv/lpcd_pkg.sv
// Shared constants and types for the LRU page cache directory.
package lpcd_pkg;

   localparam int SHIFT_W     = 5;
   localparam int OFFSET_BITS = 16;
   localparam int RSP_USER_W  = 4;

   localparam logic [SHIFT_W-1:0] MIN_SHIFT   = 5'd9;
   localparam logic [SHIFT_W-1:0] MAX_SHIFT   = 5'd16;
   localparam logic [SHIFT_W-1:0] RESET_SHIFT = 5'd12;

   // Result flags as they travel on rsp_tuser, hit in bit 0.
   typedef struct packed {
      logic access_ok;
      logic evicted;
      logic fill_request;
      logic hit;
   } rsp_flags_type;

endpackage

>>> sv/lru_page_cache_directory.sv
// LRU page cache directory: fully associative tag match, LRU pick and free-slot FIFO.
//
// Directory of a fully associative page cache with SLOTS slots and LRU
// replacement. Each request beat carries a byte address (req_tdata) and the
// outcome of the backing read (req_tuser, used on a miss only); the block
// answers with exactly one response beat per request, in order. The page
// number is the address shifted right by page_shift, which is clamped to
// 9..16 and which the user must write over the csr_ port only while the block
// is idle; the block itself does not enforce it. On a hit the slot becomes
// most recent. On a miss the slot comes from the head of the free-slot FIFO,
// or, with the FIFO empty, the least recent page is evicted; a failed fill
// invalidates the slot and returns it to the back of the FIFO. Throughput is
// one access per clock while rsp_tready is high: the tag compare against
// all slots, the LRU pick from a pairwise recency matrix and the FIFO pop/push
// all settle between the request register and the response register, and the
// state is updated at the same edge, so back-to-back accesses see each other.
// A taken request beat waits in the request register and moves on into the
// response register when that has room. While rsp_tready is low the request
// and response registers hold one access each before req_tready drops. No
// clearing pass is run after reset; reset clears valid bits and FIFO written-marks.
module lru_page_cache_directory #(
   parameter int SLOTS     = 32,
   parameter int ADDR_BITS = 48
) (
   input  logic                              clock,
   input  logic                              reset,
   // request: tdata = {pad, byte_address}; tuser = fill_ok
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [((ADDR_BITS+7)/8)*8-1:0]    req_tdata,
   input  logic                              req_tuser,
   // response: tdata = slot_index, fill_address, page_offset, evicted_page, pad
   // (lowest bits first); tuser = hit, fill_request, evicted, access_ok
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [(($clog2(SLOTS)+ADDR_BITS+lpcd_pkg::OFFSET_BITS+ADDR_BITS
                   -9+7)/8)*8-1:0]           rsp_tdata,
   output logic [lpcd_pkg::RSP_USER_W-1:0]   rsp_tuser,
   // page_shift write
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lpcd_pkg::SHIFT_W-1:0]      csr_data
);
   import lpcd_pkg::*;

   localparam int SW         = $clog2(SLOTS);
   localparam int CW         = $clog2(SLOTS+1);
   localparam int TAG_BITS   = ADDR_BITS - 9;
   localparam int RSP_RAW_W  = SW + ADDR_BITS + OFFSET_BITS + TAG_BITS;
   localparam int RSP_DATA_W = ((RSP_RAW_W+7)/8)*8;

   // ---------------------------------------------------------------- config
   logic [SHIFT_W-1:0] page_shift_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         page_shift_ff <= RESET_SHIFT;
      end else if (csr_valid) begin
         page_shift_ff <= csr_data;
      end
   end

   // --------------------------------------------------------- request stage
   logic                 s1_valid_ff;
   logic [ADDR_BITS-1:0] s1_addr_ff;
   logic                 s1_fill_ok_ff;
   logic                 advance;
   logic                 rsp_valid_ff;

   // Move the held request into the response register when there is room.
   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_addr_ff    <= req_tdata[ADDR_BITS-1:0];
         s1_fill_ok_ff <= req_tuser;
      end
   end

   // ------------------------------------------------------- address split
   logic [SHIFT_W-1:0]     shift_amt;
   logic [ADDR_BITS-1:0]   page_wide;
   logic [TAG_BITS-1:0]    page;
   logic [OFFSET_BITS:0]   off_mask;
   logic [OFFSET_BITS-1:0] page_offset;
   logic [ADDR_BITS-1:0]   page_base;

   always_comb begin
      if (page_shift_ff < MIN_SHIFT) begin
         shift_amt = MIN_SHIFT;
      end else if (page_shift_ff > MAX_SHIFT) begin
         shift_amt = MAX_SHIFT;
      end else begin
         shift_amt = page_shift_ff;
      end
   end

   assign page_wide   = s1_addr_ff >> shift_amt;
   assign page        = page_wide[TAG_BITS-1:0];
   assign off_mask    = ((OFFSET_BITS+1)'(1) << shift_amt) - (OFFSET_BITS+1)'(1);
   assign page_offset = s1_addr_ff[OFFSET_BITS-1:0] & off_mask[OFFSET_BITS-1:0];
   assign page_base   = s1_addr_ff & ({ADDR_BITS{1'b1}} << shift_amt);

   // ------------------------------------------------------ directory state
   logic [TAG_BITS-1:0] tag_ff [SLOTS];
   logic [SLOTS-1:0]    valid_ff;
   logic [SLOTS-1:0]    valid_in;
   // newer_ff[i][j] set: slot i was used more recently than slot j
   logic [SLOTS-1:0]    newer_ff [SLOTS];
   logic [SLOTS-1:0]    newer_in [SLOTS];

   // Free-slot FIFO: storage, head pointer, count, and a prefetched head entry.
   logic [SW-1:0]       fifo_mem [SLOTS];
   logic [SLOTS-1:0]    written_ff;
   logic [SLOTS-1:0]    written_in;
   logic [SW-1:0]       head_ff;
   logic [SW-1:0]       head_in;
   logic [CW-1:0]       free_count_ff;
   logic [CW-1:0]       free_count_in;
   logic [SW-1:0]       rd_addr_ff;
   logic [SW-1:0]       rd_data_ff;
   logic                rd_unwritten_ff;
   logic                rd_fwd_ff;
   logic [SW-1:0]       rd_fwd_data_ff;
   logic [SW-1:0]       head_slot;

   assign head_slot = rd_fwd_ff ? rd_fwd_data_ff :
                      (rd_unwritten_ff ? rd_addr_ff : rd_data_ff);

   // ------------------------------------------------------ match and pick
   logic [SLOTS-1:0] match;
   logic [SLOTS-1:0] lru_vec;
   logic [SW-1:0]    hit_idx;
   logic [SW-1:0]    lru_idx;
   logic [TAG_BITS-1:0] lru_tag;
   logic             found;
   logic             have_free;

   always_comb begin
      hit_idx = '0;
      lru_idx = '0;
      lru_tag = '0;
      for (int i = 0; i < SLOTS; i++) begin
         match[i]   = valid_ff[i] && (tag_ff[i] == page);
         lru_vec[i] = valid_ff[i] &&
                      ((newer_ff[i] & valid_ff & ~(SLOTS'(1) << i)) == '0);
         if (match[i]) begin
            hit_idx = hit_idx | SW'(i);
         end
         if (lru_vec[i]) begin
            lru_idx = lru_idx | SW'(i);
            lru_tag = lru_tag | tag_ff[i];
         end
      end
   end

   assign found     = |match;
   assign have_free = free_count_ff != '0;

   logic [SW-1:0]    miss_idx;
   logic             do_evict;
   logic             miss_go;
   logic             hit_go;
   logic             pop;
   logic             push;
   logic [SLOTS-1:0] miss_vec;
   logic [SLOTS-1:0] touch_vec;
   logic [SLOTS-1:0] fill_vec;
   logic [SLOTS-1:0] drop_vec;

   assign miss_idx = have_free ? head_slot : lru_idx;
   assign do_evict = !found && !have_free;
   assign hit_go   = advance && found;
   assign miss_go  = advance && !found;
   assign pop      = miss_go && have_free;
   assign push     = miss_go && !s1_fill_ok_ff;
   assign miss_vec = SLOTS'(1) << miss_idx;

   // Fill on success, drop on failure; touch makes a slot most recent.
   assign fill_vec  = (miss_go && s1_fill_ok_ff) ? miss_vec : '0;
   assign drop_vec  = push ? miss_vec : '0;
   assign touch_vec = hit_go ? match : fill_vec;
   assign valid_in  = (valid_ff | fill_vec) & ~drop_vec;

   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         newer_in[i] = touch_vec[i] ? '1 : (newer_ff[i] & ~touch_vec);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < SLOTS; i++) begin
         newer_ff[i] <= newer_in[i];
         if (fill_vec[i]) begin
            tag_ff[i] <= page;
         end
      end
   end

   // ---------------------------------------------------------- free FIFO
   logic [SW-1:0] head_next;
   logic [CW-1:0] count_after_pop;
   logic [SW:0]   wr_sum;
   logic [SW-1:0] wr_addr;

   assign head_next       = (head_ff == SW'(SLOTS-1)) ? '0 : head_ff + SW'(1);
   assign head_in         = pop ? head_next : head_ff;
   assign count_after_pop = free_count_ff - CW'(pop);
   assign free_count_in   = count_after_pop + CW'(push);
   assign wr_sum          = (SW+1)'(head_in) + (SW+1)'(count_after_pop);
   assign wr_addr         = (wr_sum >= (SW+1)'(SLOTS)) ? SW'(wr_sum - (SW+1)'(SLOTS))
                                                      : wr_sum[SW-1:0];

   always_comb begin
      written_in = written_ff;
      if (push) begin
         written_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff         <= '0;
         free_count_ff   <= CW'(SLOTS);
         written_ff      <= '0;
         rd_addr_ff      <= '0;
         rd_unwritten_ff <= 1'b1;
         rd_fwd_ff       <= 1'b0;
      end else begin
         head_ff         <= head_in;
         free_count_ff   <= free_count_in;
         written_ff      <= written_in;
         rd_addr_ff      <= head_in;
         rd_unwritten_ff <= !written_ff[head_in];
         rd_fwd_ff       <= push && (wr_addr == head_in);
      end
   end

   // Prefetch the entry at the next head; bypass a write to that same entry.
   always_ff @(posedge clock) begin
      if (push) begin
         fifo_mem[wr_addr] <= miss_idx;
      end
      rd_data_ff     <= fifo_mem[head_in];
      rd_fwd_data_ff <= miss_idx;
   end

   // ------------------------------------------------------- response stage
   rsp_flags_type          flags_in;
   rsp_flags_type          flags_ff;
   logic [SW-1:0]          slot_ff;
   logic [ADDR_BITS-1:0]   fill_addr_ff;
   logic [OFFSET_BITS-1:0] offset_ff;
   logic [TAG_BITS-1:0]    ev_page_ff;

   always_comb begin
      flags_in.hit          = found;
      flags_in.fill_request = !found;
      flags_in.evicted      = do_evict;
      flags_in.access_ok    = found || s1_fill_ok_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         flags_ff     <= flags_in;
         slot_ff      <= found ? hit_idx : miss_idx;
         fill_addr_ff <= found ? '0 : page_base;
         offset_ff    <= page_offset;
         ev_page_ff   <= do_evict ? lru_tag : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = flags_ff;
   assign rsp_tdata  = RSP_DATA_W'({ev_page_ff, offset_ff, fill_addr_ff, slot_ff});

   // ----------------------------------------------------------- assertions
   // Every slot is either cached or waiting in the free FIFO.
   a_slot_balance: assert property (@(posedge clock) disable iff (reset)
      ($countones(valid_ff) + int'(free_count_ff)) == SLOTS)
      else $error("valid slots and free count out of balance");

   // A page lives in at most one slot.
   a_unique_tag: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> $onehot0(match))
      else $error("page matched in more than one slot");

   // With no free slot left there is exactly one least recent slot.
   a_lru_pick: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !have_free) |-> $onehot(lru_vec))
      else $error("no unique LRU slot while evicting");

   // The free FIFO only hands out slots that are not cached.
   a_free_slot_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> !valid_ff[head_slot])
      else $error("free FIFO head names a valid slot");

   // A hit never asks for a fill or displaces a page.
   a_hit_clean: assert property (@(posedge clock) disable iff (reset)
      advance && found |=> !flags_ff.fill_request && !flags_ff.evicted)
      else $error("hit reported with fill or eviction");

endmodule

>>> dv/lru_page_cache_directory_tb.sv
// Self-checking testbench for the LRU page cache directory: stream stimulus, scoreboard.
`timescale 1ns / 1ps

module lru_page_cache_directory_tb;
   import lpcd_pkg::*;

   localparam int SLOTS       = 32;
   localparam int ADDR_BITS   = 48;
   localparam int REQ_W       = ((ADDR_BITS + 7) / 8) * 8;
   localparam int RSP_W       = (($clog2(SLOTS) + ADDR_BITS + OFFSET_BITS + ADDR_BITS - 9 + 7)
                                 / 8) * 8;
   localparam int CYCLE_LIMIT = 500000;
   localparam int HOLD_CYCLES = 300;

   // One access as offered on the request stream.
   typedef struct packed {
      logic [47:0] addr;
      logic        fill_ok;
   } access_type;

   // One directory answer, unpacked from rsp_tdata and rsp_tuser.
   typedef struct packed {
      logic        hit;
      logic [4:0]  slot_index;
      logic        fill_request;
      logic [47:0] fill_address;
      logic [15:0] page_offset;
      logic        evicted;
      logic [38:0] evicted_page;
      logic        access_ok;
   } dir_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [REQ_W-1:0]   req_tdata  = '0;
   logic               req_tuser  = 1'b0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [RSP_W-1:0]   rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic               csr_valid  = 1'b0;
   logic               csr_ready;
   logic [SHIFT_W-1:0] csr_data   = '0;

   lru_page_cache_directory #(
      .SLOTS     (SLOTS),
      .ADDR_BITS (ADDR_BITS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Stimulus waiting for the driver, and answers waiting for the DUT.
   access_type     access_queue[$];
   dir_result_type lookup_results[$];

   // Shadow copy of the directory state.
   logic [SHIFT_W-1:0] page_shift_reg;
   logic [38:0]        dir_tag[SLOTS];
   bit                 dir_valid[SLOTS];
   int                 lru_order[$];     // least recent slot first
   int                 free_slots[$];    // head of the free FIFO first

   // Idle controls, changed only between phases while the DUT is idle.
   bit req_idle_en = 1'b1;
   bit rsp_idle_en = 1'b1;
   bit hold_go     = 1'b0;
   logic rsp_hold  = 1'b0;

   int error_count = 0;
   int result_count = 0;
   int cycle_count = 0;

   function automatic int draw_wait(input bit enabled);
      return enabled ? $urandom_range(0, 8) : 0;
   endfunction

   // Clamp the register the way the block does: 9..16.
   function automatic int eff_shift();
      if (page_shift_reg < MIN_SHIFT) return int'(MIN_SHIFT);
      if (page_shift_reg > MAX_SHIFT) return int'(MAX_SHIFT);
      return int'(page_shift_reg);
   endfunction

   function automatic logic [47:0] rand48();
      return 48'({$urandom(), $urandom()});
   endfunction

   function automatic string fmt_result(input dir_result_type r);
      return $sformatf("hit=%0d slot=%0d fill=%0d addr=%h off=%h ev=%0d page=%h ok=%0d",
                       r.hit, r.slot_index, r.fill_request, r.fill_address,
                       r.page_offset, r.evicted, r.evicted_page, r.access_ok);
   endfunction

   // Look up one access in the shadow directory, update it and queue the answer.
   task automatic directory_lookup(input access_type acc);
      dir_result_type r;
      logic [63:0] page;
      int sh;
      int pos;
      int slot;
      sh   = eff_shift();
      page = {16'd0, acc.addr} >> sh;
      r    = '0;
      r.access_ok   = 1'b1;
      r.page_offset = 16'({16'd0, acc.addr} & ((64'd1 << sh) - 64'd1));
      pos  = -1;
      slot = 0;
      // Tags stay as written under an older shift; compare them against the new page.
      for (int i = 0; i < lru_order.size() && pos < 0; i++) begin
         if (dir_valid[lru_order[i]] && {25'd0, dir_tag[lru_order[i]]} == page) pos = i;
      end
      if (pos >= 0) begin
         // Hit: move the slot to the most recent end, fill_ok is ignored.
         slot = lru_order[pos];
         lru_order.delete(pos);
         lru_order.insert(lru_order.size(), slot);
         r.hit = 1'b1;
      end else begin
         if (free_slots.size() != 0) begin
            slot = free_slots[0];
            free_slots.delete(0);
         end else if (lru_order.size() != 0) begin
            slot = lru_order[0];
            lru_order.delete(0);
            if (dir_valid[slot]) begin
               r.evicted      = 1'b1;
               r.evicted_page = dir_tag[slot];
            end
         end
         r.fill_request = 1'b1;
         r.fill_address = 48'(page << sh);
         if (acc.fill_ok) begin
            dir_tag[slot]   = page[38:0];
            dir_valid[slot] = 1'b1;
            lru_order.insert(lru_order.size(), slot);
         end else begin
            // Failed fill: the slot goes back to the tail of the free FIFO, any
            // evicted page stays lost.
            dir_valid[slot] = 1'b0;
            if (free_slots.size() < SLOTS) free_slots.insert(free_slots.size(), slot);
            r.access_ok = 1'b0;
         end
      end
      r.slot_index = slot[4:0];
      lookup_results.insert(lookup_results.size(), r);
   endtask

   // Request driver: present queued accesses, predict each one as its beat is taken.
   int req_wait = 0;
   always @(posedge clock) begin
      access_type acc;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_wait = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            directory_lookup({req_tdata[47:0], req_tuser});
            req_wait = draw_wait(req_idle_en);
         end
         if (!req_tvalid || req_tready) begin
            if (req_wait != 0) begin
               req_wait--;
               req_tvalid <= 1'b0;
            end else if (access_queue.size() != 0) begin
               acc = access_queue[0];
               access_queue.delete(0);
               req_tvalid <= 1'b1;
               req_tdata  <= REQ_W'(acc.addr);
               req_tuser  <= acc.fill_ok;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: check each taken beat against the oldest answer, pace tready.
   int rsp_wait = 0;
   always @(posedge clock) begin
      dir_result_type got;
      dir_result_type want;
      rsp_flags_type  flags;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            flags            = rsp_flags_type'(rsp_tuser);
            got.hit          = flags.hit;
            got.fill_request = flags.fill_request;
            got.evicted      = flags.evicted;
            got.access_ok    = flags.access_ok;
            got.slot_index   = rsp_tdata[4:0];
            got.fill_address = rsp_tdata[52:5];
            got.page_offset  = rsp_tdata[68:53];
            got.evicted_page = rsp_tdata[107:69];
            if (lookup_results.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("result %0d arrived with no access outstanding", result_count);
            end else begin
               want = lookup_results[0];
               lookup_results.delete(0);
               if (got != want) begin
                  error_count++;
                  if (error_count <= 10) begin
                     $display("result %0d mismatch, expected: %s", result_count,
                              fmt_result(want));
                     $display("result %0d mismatch, actual:   %s", result_count,
                              fmt_result(got));
                  end
               end
            end
            result_count++;
            rsp_wait = draw_wait(rsp_idle_en);
         end
         if (rsp_hold) begin
            rsp_tready <= 1'b0;
         end else if (rsp_wait != 0) begin
            rsp_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Long receiver stall: hold tready low so the DUT backs up into req_tready.
   initial begin
      wait (hold_go);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("lru_page_cache_directory test failed");
         $finish;
      end
   end

   task automatic queue_one(input logic [47:0] addr, input logic ok);
      access_type acc;
      acc.addr    = addr;
      acc.fill_ok = ok;
      access_queue.insert(access_queue.size(), acc);
   endtask

   // Queue a phase of accesses: mostly a working set of pages (hits, and
   // evictions once the set outgrows the slots), some pages rebuilt from tags
   // already stored, and some fully random addresses.
   task automatic queue_accesses(input int count, input int pool_size, input int fail_pct);
      logic [47:0] pool[$];
      logic [47:0] a;
      logic [47:0] ofs_mask;
      int sh;
      int pick;
      int k;
      sh       = eff_shift();
      ofs_mask = (48'd1 << sh) - 48'd1;
      repeat (pool_size) pool.insert(pool.size(), rand48() >> sh);
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            a = rand48();
         end else if (pick < 16 && lru_order.size() != 0) begin
            k = lru_order[$urandom_range(0, lru_order.size() - 1)];
            a = 48'({25'd0, dir_tag[k]} << sh) | (rand48() & ofs_mask);
         end else begin
            a = (pool[$urandom_range(0, pool_size - 1)] << sh) | (rand48() & ofs_mask);
         end
         queue_one(a, $urandom_range(0, 99) >= fail_pct);
      end
   endtask

   // Drain: no stimulus left, no beat on the wire and no answer outstanding.
   task automatic wait_idle();
      @(negedge clock);
      while (access_queue.size() != 0 || req_tvalid || lookup_results.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_page_shift(input logic [SHIFT_W-1:0] value);
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      page_shift_reg = value;
      @(negedge clock);
   endtask

   // Phase plan: register values cover the clamp at both ends and out of range.
   logic [SHIFT_W-1:0] shift_plan[9] = '{5'd9, 5'd16, 5'd0, 5'd31, 5'd8, 5'd17, 5'd13,
                                         5'd16, 5'd9};
   int pool_plan[9] = '{24, 48, 40, 20, 36, 60, 28, 44, 33};
   int fail_plan[9] = '{15, 10, 20, 50, 5, 15, 12, 25, 0};

   initial begin
      page_shift_reg = RESET_SHIFT;
      for (int s = 0; s < SLOTS; s++) begin
         dir_valid[s] = 1'b0;
         dir_tag[s]   = '0;
         free_slots.insert(free_slots.size(), s);
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed opening at the reset page size.
      queue_one(48'h0000_0000_0000, 1'b1);   // first miss takes slot 0
      queue_one(48'h0000_0000_0FFF, 1'b0);   // hit, top offset, fill_ok ignored
      queue_one(48'hFFFF_FFFF_FFFF, 1'b1);   // top page
      queue_one(48'hFFFF_FFFF_F000, 1'b1);   // hit on top page, zero offset
      queue_one(48'h1234_5678_9ABC, 1'b0);   // failed fill, slot back to FIFO tail
      queue_one(48'h1234_5678_9ABC, 1'b1);   // same page misses again
      queue_one(48'h1234_5678_9000, 1'b0);   // now a hit
      queue_one(48'h8000_0000_0000, 1'b1);
      queue_one(48'h5555_5555_5555, 1'b1);
      queue_one(48'hAAAA_AAAA_AAAA, 1'b1);
      queue_one(48'h5555_5555_5AAA, 1'b1);   // hit reorders recency
      queue_one(48'h0000_0000_1000, 1'b0);   // neighbor page fails
      queue_one(48'h0000_0000_0001, 1'b1);
      queue_accesses(160, 40, 15);
      wait_idle();

      for (int p = 0; p < 9; p++) begin
         write_page_shift(shift_plan[p]);
         req_idle_en = (p != 1 && p != 4);
         rsp_idle_en = (p != 4 && p != 6);
         if (p == 1) hold_go = 1'b1;
         queue_accesses(175, pool_plan[p], fail_plan[p]);
         // Sender pause mid-phase until every answer is back.
         if (p == 5) begin
            wait_idle();
            queue_accesses(20, pool_plan[p], fail_plan[p]);
         end
         wait_idle();
      end

      repeat (20) @(posedge clock);
      if (error_count == 0 && lookup_results.size() == 0) begin
         $display("lru_page_cache_directory test passed");
      end else begin
         $display("lru_page_cache_directory test failed");
      end
      $finish;
   end

endmodule
